### design/ccgr_pkg.sv
// Shared types, constants and tables of the caption glyph rasterizer.
`default_nettype none

package ccgr_pkg;

    // Default sizes of the font store and the cell
    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int ROWS_PER_GLYPH_DEF = 26;
    localparam int CELL_WIDTH_DEF     = 16;

    // Fixed field widths
    localparam int CODE_W  = 16;
    localparam int COLOR_W = 4;
    localparam int ROW_W   = 5;
    localparam int FBITS_W = 16;
    localparam int GNUM_W  = 8;
    localparam int PIX_W   = 64;
    localparam int NIBBLES = PIX_W / COLOR_W;

    // Input tdata layout, lowest field first
    localparam int IN_GLYPH_LSB = 0;
    localparam int IN_ROW_LSB   = IN_GLYPH_LSB + GNUM_W;
    localparam int IN_BITS_LSB  = IN_ROW_LSB + ROW_W;
    localparam int IN_CODE_LSB  = IN_BITS_LSB + FBITS_W;
    localparam int IN_ITAL_BIT  = IN_CODE_LSB + CODE_W;
    localparam int IN_UNDER_BIT = IN_ITAL_BIT + 1;
    localparam int IN_FG_LSB    = IN_UNDER_BIT + 1;
    localparam int IN_USED_W    = IN_FG_LSB + COLOR_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first
    localparam int OUT_USED_W  = ROW_W + PIX_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Kind codes carried in tuser
    localparam logic KIND_FONT = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    localparam logic [COLOR_W-1:0] BG_RESET = 4'd8;

    // Glyph mapping constants
    localparam logic [CODE_W-1:0] CODE_PRINT_LO = 16'h0020;
    localparam logic [CODE_W-1:0] CODE_PRINT_HI = 16'h0080;
    localparam logic [8:0]        BAD_GLYPH     = 9'd15;
    localparam logic [8:0]        ITALIC_OFFSET = 9'(4 * 32);
    localparam logic [8:0]        SPECIAL_BASE  = 9'd6;
    localparam logic [31:0]       UNDERLINE_ROWS = 32'(3 << 24);

    localparam int SPECIAL_COUNT = 26;
    localparam logic [CODE_W-1:0] SPECIAL_CODES [SPECIAL_COUNT] = '{
        16'h00E1, 16'h00E9, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00E7, 16'h00F7, 16'h00D1,
        16'h00F1, 16'h25A0, 16'h00AE, 16'h00B0, 16'h00BD, 16'h00BF, 16'h2122, 16'h00A2,
        16'h00A3, 16'h266A, 16'h00E0, 16'h0020, 16'h00E8, 16'h00E2, 16'h00EA, 16'h00EE,
        16'h00F4, 16'h00FB
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_RUN
    } t_state;

    // Per-cycle control from the sequencer to the row unit
    typedef struct packed {
        logic             load_base;
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             load_out;
    } t_ctrl;

endpackage

`default_nettype wire

### design/caption_glyph_rasterizer.sv
// Top level of the caption glyph rasterizer.
`default_nettype none

// Character generator for caption cells. Font-write items (tuser = 0) store
// one glyph row into the font store and produce nothing. Draw items
// (tuser = 1) map the character code to a glyph (printable ASCII as is, 25
// special characters to glyphs 6..31 but 25, everything else to glyph 15,
// italic adds 128) and then emit ROWS_PER_GLYPH items, one per pixel row,
// each with CELL_WIDTH 4-bit palette indices, pixel zero in the low nibble;
// tlast marks the final row. Underline forces cell rows 24 and 25 to the
// foreground color. A draw is accepted, mapped to a glyph in the mapping
// state, starts its first font store read and then yields one row per cycle
// through the shared row unit, which issues one font store read per cycle
// while the output register is free; a stalled sink holds both back. The
// slave side is not ready until the last row of a cell has been taken. The
// font store holds no defined data after reset: draw only glyph rows that
// were written. Write the background color only while the block is idle.

module caption_glyph_rasterizer #(
    parameter int GLYPH_COUNT    = ccgr_pkg::GLYPH_COUNT_DEF,
    parameter int ROWS_PER_GLYPH = ccgr_pkg::ROWS_PER_GLYPH_DEF,
    parameter int CELL_WIDTH     = ccgr_pkg::CELL_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ccgr_pkg::COLOR_W-1:0]     i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // font_glyph[7:0], font_row[12:8], font_bits[28:13], char_code[44:29],
    // italic[45], underline[46], fg_color[50:47], zero fill[55:51]
    input  wire logic [ccgr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // row_index[4:0], pixels[68:5], zero fill[71:69]
    output logic      [ccgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // last_row
    output logic                                  m_axis_tlast
);

    import ccgr_pkg::*;

    localparam int GW    = $clog2(GLYPH_COUNT);
    localparam int DEPTH = GLYPH_COUNT * ROWS_PER_GLYPH;
    localparam int AW    = $clog2(DEPTH);

    // Input field unpacking
    logic [GNUM_W-1:0]  w_in_glyph;
    logic [ROW_W-1:0]   w_in_row;
    logic [FBITS_W-1:0] w_in_bits;
    logic [CODE_W-1:0]  w_in_code;
    logic               w_in_italic;
    logic               w_in_under;
    logic [COLOR_W-1:0] w_in_fg;

    assign w_in_glyph  = s_axis_tdata[IN_GLYPH_LSB +: GNUM_W];
    assign w_in_row    = s_axis_tdata[IN_ROW_LSB +: ROW_W];
    assign w_in_bits   = s_axis_tdata[IN_BITS_LSB +: FBITS_W];
    assign w_in_code   = s_axis_tdata[IN_CODE_LSB +: CODE_W];
    assign w_in_italic = s_axis_tdata[IN_ITAL_BIT];
    assign w_in_under  = s_axis_tdata[IN_UNDER_BIT];
    assign w_in_fg     = s_axis_tdata[IN_FG_LSB +: COLOR_W];

    logic w_accept;
    logic w_draw;
    logic w_font_we;

    assign w_accept = s_axis_tvalid & s_axis_tready;
    assign w_draw   = w_accept & (s_axis_tuser == KIND_DRAW);

    // Drop font writes that fall outside the store
    assign w_font_we = w_accept & (s_axis_tuser == KIND_FONT)
                     & ({1'b0, w_in_glyph} < 9'(GLYPH_COUNT))
                     & (w_in_row < ROW_W'(ROWS_PER_GLYPH));

    logic [AW-1:0] w_waddr;
    assign w_waddr = AW'(AW'(GW'(w_in_glyph)) * AW'(ROWS_PER_GLYPH) + AW'(w_in_row));

    // Background color register
    logic [COLOR_W-1:0] r_bg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            r_bg <= i_cfg_wdata;
        end
    end

    // Hold the draw item for the whole cell
    logic [CODE_W-1:0]  r_code;
    logic               r_italic;
    logic               r_under;
    logic [COLOR_W-1:0] r_fg;
    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_code   <= w_in_code;
            r_italic <= w_in_italic;
            r_under  <= w_in_under;
            r_fg     <= w_in_fg;
        end
    end

    logic [GW-1:0] w_glyph;
    ccgr_glyph_map #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_map (
        .i_code   (r_code),
        .i_italic (r_italic),
        .o_glyph  (w_glyph)
    );

    t_ctrl w_ctrl;
    logic  w_last;

    ccgr_seq #(
        .ROWS_PER_GLYPH (ROWS_PER_GLYPH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_draw      (w_draw),
        .i_out_ready (m_axis_tready),
        .i_out_last  (w_last),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ctrl      (w_ctrl)
    );

    logic [CELL_WIDTH-1:0] w_rdata;
    logic [AW-1:0]         w_raddr;

    ccgr_ram #(
        .WIDTH (CELL_WIDTH),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (w_font_we),
        .i_waddr (w_waddr),
        .i_wdata (w_in_bits[CELL_WIDTH-1:0]),
        .i_re    (w_ctrl.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [ROW_W-1:0] w_row;
    logic [PIX_W-1:0] w_pix;

    ccgr_row_unit #(
        .GLYPH_COUNT    (GLYPH_COUNT),
        .ROWS_PER_GLYPH (ROWS_PER_GLYPH),
        .CELL_WIDTH     (CELL_WIDTH)
    ) u_row (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_glyph     (w_glyph),
        .i_underline (r_under),
        .i_fg        (r_fg),
        .i_bg        (r_bg),
        .i_rdata     (w_rdata),
        .o_raddr     (w_raddr),
        .o_row       (w_row),
        .o_pixels    (w_pix),
        .o_last      (w_last)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_pix, w_row});
    assign m_axis_tlast = w_last;

endmodule

`default_nettype wire

### design/ccgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ccgr_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 6656,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### design/ccgr_glyph_map.sv
// Maps a character code and italic flag to a glyph number.
`default_nettype none

module ccgr_glyph_map #(
    parameter  int GLYPH_COUNT = ccgr_pkg::GLYPH_COUNT_DEF,
    localparam int GW          = $clog2(GLYPH_COUNT)
) (
    input  wire logic [ccgr_pkg::CODE_W-1:0] i_code,
    input  wire logic                        i_italic,
    output logic      [GW-1:0]               o_glyph
);

    import ccgr_pkg::*;

    logic [8:0] w_special;
    logic [8:0] w_base;
    logic [8:0] w_glyph;

    // Search descending so the lowest matching index wins
    always_comb begin
        w_special = BAD_GLYPH;
        for (int k = SPECIAL_COUNT - 1; k >= 0; k--) begin
            if (SPECIAL_CODES[k] == i_code) begin
                w_special = 9'(k) + SPECIAL_BASE;
            end
        end
    end

    always_comb begin
        if (i_code < CODE_PRINT_LO) begin
            w_base = BAD_GLYPH;
        end else if (i_code < CODE_PRINT_HI) begin
            w_base = 9'(i_code);
        end else begin
            w_base = w_special;
        end
        w_glyph = i_italic ? (w_base + ITALIC_OFFSET) : w_base;
        if (w_glyph >= 9'(GLYPH_COUNT)) begin
            w_glyph = BAD_GLYPH;
        end
    end

    assign o_glyph = GW'(w_glyph);

endmodule

`default_nettype wire

### design/ccgr_row_unit.sv
// Row unit: font store read address and pixel row expansion, reused per row.
`default_nettype none

module ccgr_row_unit #(
    parameter  int GLYPH_COUNT    = ccgr_pkg::GLYPH_COUNT_DEF,
    parameter  int ROWS_PER_GLYPH = ccgr_pkg::ROWS_PER_GLYPH_DEF,
    parameter  int CELL_WIDTH     = ccgr_pkg::CELL_WIDTH_DEF,
    localparam int GW             = $clog2(GLYPH_COUNT),
    localparam int AW             = $clog2(GLYPH_COUNT * ROWS_PER_GLYPH)
) (
    input  wire logic                         i_clk,
    input  wire ccgr_pkg::t_ctrl              i_ctrl,
    input  wire logic [GW-1:0]                i_glyph,
    input  wire logic                         i_underline,
    input  wire logic [ccgr_pkg::COLOR_W-1:0] i_fg,
    input  wire logic [ccgr_pkg::COLOR_W-1:0] i_bg,
    input  wire logic [CELL_WIDTH-1:0]        i_rdata,
    output logic      [AW-1:0]                o_raddr,
    output logic      [ccgr_pkg::ROW_W-1:0]   o_row,
    output logic      [ccgr_pkg::PIX_W-1:0]   o_pixels,
    output logic                              o_last
);

    import ccgr_pkg::*;

    logic [AW-1:0]    r_base;
    logic [ROW_W-1:0] r_a_row;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_pix;
    logic             r_last;

    logic [FBITS_W-1:0] w_bits;
    logic [PIX_W-1:0]   w_pix;
    logic               w_under_row;

    assign o_raddr = r_base + AW'(i_ctrl.rd_row);

    // Underlined rows bypass the font data
    assign w_under_row = i_underline & UNDERLINE_ROWS[r_a_row];
    assign w_bits      = w_under_row ? '1 : FBITS_W'(i_rdata);

    always_comb begin
        w_pix = '0;
        for (int x = 0; x < NIBBLES; x++) begin
            if (x < CELL_WIDTH) begin
                w_pix[x*COLOR_W +: COLOR_W] = w_bits[x] ? i_fg : i_bg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_base) begin
            r_base <= AW'(AW'(i_glyph) * AW'(ROWS_PER_GLYPH));
        end
        if (i_ctrl.rd_en) begin
            r_a_row <= i_ctrl.rd_row;
        end
        if (i_ctrl.load_out) begin
            r_row  <= r_a_row;
            r_pix  <= w_pix;
            r_last <= (r_a_row == ROW_W'(ROWS_PER_GLYPH - 1));
        end
    end

    assign o_row    = r_row;
    assign o_pixels = r_pix;
    assign o_last   = r_last;

endmodule

`default_nettype wire

### design/ccgr_seq.sv
// Sequencer: cell state machine, row counter and read/output stage tracking.
`default_nettype none

module ccgr_seq #(
    parameter int ROWS_PER_GLYPH = ccgr_pkg::ROWS_PER_GLYPH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_draw,
    input  wire logic            i_out_ready,
    input  wire logic            i_out_last,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output ccgr_pkg::t_ctrl      o_ctrl
);

    import ccgr_pkg::*;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_issue_row, n_issue_row;
    logic             r_more, n_more;
    logic             r_a_vld, n_a_vld;
    logic             r_out_vld, n_out_vld;

    logic w_out_free;
    logic w_out_take;

    assign w_out_free = ~r_out_vld | i_out_ready;
    assign w_out_take = r_out_vld & i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_draw) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (w_out_take && i_out_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready       = 1'b0;
        o_ctrl.load_base = 1'b0;
        o_ctrl.rd_en     = 1'b0;
        o_ctrl.rd_row    = r_issue_row;
        o_ctrl.load_out  = r_a_vld & w_out_free;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_MAP: begin
                o_ctrl.load_base = 1'b1;
            end
            S_RUN: begin
                o_ctrl.rd_en = r_more & (~r_a_vld | w_out_free);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Row counter and stage valids
    always_comb begin
        n_issue_row = r_issue_row;
        n_more      = r_more;
        if (r_state == S_MAP) begin
            n_issue_row = '0;
            n_more      = 1'b1;
        end else if (o_ctrl.rd_en) begin
            n_issue_row = r_issue_row + 1'b1;
            if (r_issue_row == ROW_W'(ROWS_PER_GLYPH - 1)) begin
                n_more = 1'b0;
            end
        end

        if (o_ctrl.rd_en) begin
            n_a_vld = 1'b1;
        end else if (o_ctrl.load_out) begin
            n_a_vld = 1'b0;
        end else begin
            n_a_vld = r_a_vld;
        end

        if (o_ctrl.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue_row <= '0;
            r_more      <= 1'b0;
            r_a_vld     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue_row <= n_issue_row;
            r_more      <= n_more;
            r_a_vld     <= n_a_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the caption glyph rasterizer: font loads, cell draws, colors.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Sizes of the block as built here (default parameters)
    localparam int GLYPHS    = 256;
    localparam int CELL_ROWS = 26;
    localparam int CELL_COLS = 16;
    localparam int STALL_LIMIT = 3000;

    // Glyph mapping: codes that leave the printable range through the
    // specials table land on glyph 6 + position in this list
    localparam int SPECIAL_BASE = 6;
    localparam int ERROR_GLYPH = 15;
    localparam int SLANT_OFFSET = 128;
    localparam logic [31:0] UNDERLINED_ROWS = 32'h0300_0000;
    localparam logic [15:0] CAPTION_SPECIALS [26] = '{
        16'h00E1, 16'h00E9, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00E7, 16'h00F7, 16'h00D1,
        16'h00F1, 16'h25A0, 16'h00AE, 16'h00B0, 16'h00BD, 16'h00BF, 16'h2122, 16'h00A2,
        16'h00A3, 16'h266A, 16'h00E0, 16'h0020, 16'h00E8, 16'h00E2, 16'h00EA, 16'h00EE,
        16'h00F4, 16'h00FB
    };

    // One input item, both kinds share the fields
    typedef struct packed {
        logic        kind;
        logic [7:0]  font_glyph;
        logic [4:0]  font_row;
        logic [15:0] font_bits;
        logic [15:0] char_code;
        logic        italic;
        logic        underline;
        logic [3:0]  fg_color;
    } cell_req_t;

    // One pixel row of a drawn cell
    typedef struct packed {
        logic [4:0]  row_index;
        logic [63:0] pixels;
        logic        last_row;
    } cell_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ccgr_pkg::COLOR_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [ccgr_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [ccgr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;

    // Shadow of the font store and of the background register
    logic [15:0] font_shadow [0:GLYPHS*CELL_ROWS-1];
    bit          row_written [0:GLYPHS*CELL_ROWS-1];
    bit          glyph_listed [0:GLYPHS-1];
    int          drawable [$];     // glyphs with at least rows 0..23 loaded
    logic [3:0]  background = ccgr_pkg::BG_RESET;

    cell_row_t pending_rows [$];   // pixel rows still owed by the block
    cell_row_t want_row;
    cell_row_t got_row;
    int        fail_count = 0;
    int        accepted_items = 0;
    int        stall_cycles = 0;
    bit        src_burst = 1'b0;
    bit        sink_burst = 1'b0;
    int        sink_hold = 0;

    caption_glyph_rasterizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle length: mostly a few cycles, now and then a long pause
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 92) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(12, 40);
    endfunction

    // Map a character code to the glyph it draws
    function automatic int glyph_for_code(logic [15:0] code, logic slanted);
        int g;
        bit found;
        g = ERROR_GLYPH;
        found = 1'b0;
        if (code >= 16'h0020 && code < 16'h0080) begin
            g = int'(code);
        end else if (code >= 16'h0080) begin
            for (int k = 0; k < 26; k++) begin
                if (!found && CAPTION_SPECIALS[k] == code) begin
                    g = SPECIAL_BASE + k;
                    found = 1'b1;
                end
            end
        end
        if (slanted) begin
            g += SLANT_OFFSET;
        end
        if (g >= GLYPHS) begin
            g = ERROR_GLYPH;
        end
        return g;
    endfunction

    // Pick some code that maps to the given upright glyph
    function automatic logic [15:0] code_for_glyph(int base);
        logic [15:0] c;
        if (base >= 32) begin
            return 16'(base);
        end
        if (base != ERROR_GLYPH) begin
            return CAPTION_SPECIALS[base - SPECIAL_BASE];
        end
        case ($urandom_range(0, 2))
            0: c = 16'($urandom_range(0, 31));
            1: c = 16'h25A0;
            default: begin
                do c = 16'($urandom_range(16'h0080, 16'hFFFF));
                while (glyph_for_code(c, 1'b0) != ERROR_GLYPH);
            end
        endcase
        return c;
    endfunction

    // Any glyph some code can reach; upright glyph 25 has no code
    function automatic int random_reachable();
        int base;
        do base = $urandom_range(6, 127);
        while (base == 25);
        return base + ($urandom_range(0, 1) ? SLANT_OFFSET : 0);
    endfunction

    // Work out the 26 pixel rows a draw item must produce
    function automatic void rasterize_cell(cell_req_t req);
        int g;
        logic [15:0] bits;
        cell_row_t r;
        g = glyph_for_code(req.char_code, req.italic);
        for (int y = 0; y < CELL_ROWS; y++) begin
            if (req.underline && UNDERLINED_ROWS[y]) begin
                bits = 16'hFFFF;
            end else begin
                bits = font_shadow[g * CELL_ROWS + y];
            end
            r.row_index = 5'(y);
            r.pixels = '0;
            for (int x = 0; x < CELL_COLS; x++) begin
                r.pixels[4*x +: 4] = bits[x] ? req.fg_color : background;
            end
            r.last_row = (y == CELL_ROWS - 1);
            pending_rows.push_back(r);
        end
    endfunction

    // Send one item, then fold it into the shadow state once accepted
    task automatic push_item(input cell_req_t req);
        int gap;
        logic [ccgr_pkg::IN_TDATA_W-1:0] word;
        gap = (src_burst || $urandom_range(0, 1)) ? 0 : idle_length();
        word = '0;
        word[ccgr_pkg::IN_GLYPH_LSB +: ccgr_pkg::GNUM_W]  = req.font_glyph;
        word[ccgr_pkg::IN_ROW_LSB +: ccgr_pkg::ROW_W]     = req.font_row;
        word[ccgr_pkg::IN_BITS_LSB +: ccgr_pkg::FBITS_W]  = req.font_bits;
        word[ccgr_pkg::IN_CODE_LSB +: ccgr_pkg::CODE_W]   = req.char_code;
        word[ccgr_pkg::IN_ITAL_BIT]                       = req.italic;
        word[ccgr_pkg::IN_UNDER_BIT]                      = req.underline;
        word[ccgr_pkg::IN_FG_LSB +: ccgr_pkg::COLOR_W]    = req.fg_color;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= req.kind;
        do @(posedge i_clk);
        while (!s_axis_tready);
        if (req.kind == ccgr_pkg::KIND_FONT) begin
            // rows past the glyph height are dropped by the block
            if (req.font_row < CELL_ROWS) begin
                font_shadow[req.font_glyph * CELL_ROWS + req.font_row] = req.font_bits;
                row_written[req.font_glyph * CELL_ROWS + req.font_row] = 1'b1;
                accepted_items++;
            end
        end else begin
            rasterize_cell(req);
            accepted_items++;
        end
    endtask

    // Font write; the draw fields ride along as noise
    task automatic write_row(input int g, input int row, input logic [15:0] bits);
        cell_req_t req;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        req = noise[$bits(cell_req_t)-1:0];
        req.kind = ccgr_pkg::KIND_FONT;
        req.font_glyph = 8'(g);
        req.font_row = 5'(row);
        req.font_bits = bits;
        push_item(req);
    endtask

    // Draw item; the font fields ride along as noise
    task automatic draw(input logic [15:0] code, input logic slanted, input logic under,
                        input logic [3:0] fg);
        cell_req_t req;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        req = noise[$bits(cell_req_t)-1:0];
        req.kind = ccgr_pkg::KIND_DRAW;
        req.char_code = code;
        req.italic = slanted;
        req.underline = under;
        req.fg_color = fg;
        push_item(req);
    endtask

    // Load the first nrows rows of a glyph, starting at a random row and
    // sprinkling in writes past the glyph height that must be dropped
    task automatic load_glyph(input int g, input int nrows);
        int first;
        logic [15:0] bits;
        first = $urandom_range(0, nrows - 1);
        for (int k = 0; k < nrows; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                write_row(g, $urandom_range(CELL_ROWS, 31), 16'($urandom));
            end
            case ($urandom_range(0, 7))
                0: bits = 16'h0000;
                1: bits = 16'hFFFF;
                default: bits = 16'($urandom);
            endcase
            write_row(g, (first + k) % nrows, bits);
        end
        if (!glyph_listed[g]) begin
            glyph_listed[g] = 1'b1;
            drawable.push_back(g);
        end
    endtask

    // Drop valid, wait for every owed row, then let the block settle
    task automatic wait_idle(input int settle);
        s_axis_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_background(input logic [3:0] color);
        wait_idle(8);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= color;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        background = color;
    endtask

    // Preload the glyphs the directed draws use
    task automatic test_font_preload();
        load_glyph(ERROR_GLYPH, CELL_ROWS);
        load_glyph(ERROR_GLYPH + SLANT_OFFSET, CELL_ROWS);
        load_glyph(32, CELL_ROWS);
        load_glyph(127, CELL_ROWS);
        load_glyph(127 + SLANT_OFFSET, CELL_ROWS);
        load_glyph(SPECIAL_BASE, CELL_ROWS);
        load_glyph(31, CELL_ROWS);
    endtask

    // Every branch of the code mapping, with the reset background
    task automatic test_glyph_mapping();
        draw(16'h0000, 1'b0, 1'b0, 4'd0);   // control code
        draw(16'h001F, 1'b0, 1'b0, 4'd9);   // top control code
        draw(16'h0020, 1'b0, 1'b1, 4'd15);  // space, printable first
        draw(16'h007F, 1'b0, 1'b0, 4'd3);   // top of printable range
        draw(16'h0080, 1'b0, 1'b0, 4'd5);   // just past printable, not special
        draw(16'hFFFF, 1'b1, 1'b1, 4'd15);  // unknown code, slanted
        draw(16'h00E1, 1'b0, 1'b0, 4'd1);   // first special
        draw(16'h00FB, 1'b0, 1'b1, 4'd7);   // last special
        draw(16'h007F, 1'b1, 1'b0, 4'd2);   // highest glyph of the store
        draw(16'h25A0, 1'b0, 1'b0, 4'd4);   // special that lands on glyph 15
    endtask

    // Background extremes and foreground colors 0, 9, 10 and 15
    task automatic test_colors();
        set_background(4'd0);
        draw(16'h0020, 1'b0, 1'b0, 4'd9);
        draw(16'h0010, 1'b1, 1'b0, 4'd15);
        set_background(4'd15);
        draw(16'h007F, 1'b0, 1'b1, 4'd0);
        draw(16'h00FB, 1'b0, 1'b0, 4'd10);
    endtask

    // Writes past the glyph height must leave the store untouched; in-range writes mixed in still land
    task automatic test_dropped_writes();
        write_row(ERROR_GLYPH, CELL_ROWS, 16'hFFFF);
        write_row(ERROR_GLYPH, 31, 16'hFFFF);
        write_row(0, 31, 16'h5A5A);
        draw(16'h0005, 1'b0, 1'b0, 4'd6);
        write_row(255, CELL_ROWS - 1, 16'h0000);
        write_row(0, 0, 16'hFFFF);
        draw(16'h007F, 1'b1, 1'b0, 4'd9);
        set_background(4'd9);
    endtask

    // Mostly load-then-draw sequences, with stray writes mixed in
    task automatic test_random_traffic();
        int start;
        int g;
        logic under;
        start = accepted_items;
        for (int phase = 0; phase < 3; phase++) begin
            set_background(4'($urandom_range(0, 15)));
            while (accepted_items - start < 90 * (phase + 1)) begin
                if ($urandom_range(0, 39) == 0) begin
                    src_burst = !src_burst;
                end
                case ($urandom_range(0, 24))
                    0: load_glyph(random_reachable(), $urandom_range(0, 4) ? CELL_ROWS : 24);
                    1, 2, 3: write_row($urandom_range(0, GLYPHS - 1), $urandom_range(0, 31),
                                       16'($urandom));
                    default: begin
                        if ($urandom_range(0, 99) < 8) begin
                            g = random_reachable();
                            if (!glyph_listed[g]) begin
                                load_glyph(g, $urandom_range(0, 3) ? CELL_ROWS : 24);
                            end
                        end else begin
                            g = drawable[$urandom_range(0, drawable.size() - 1)];
                        end
                        // a glyph without rows 24 and 25 may only be drawn underlined
                        under = 1'($urandom_range(0, 1));
                        if (!row_written[g * CELL_ROWS + 24] || !row_written[g * CELL_ROWS + 25]) begin
                            under = 1'b1;
                        end
                        draw(code_for_glyph(g % SLANT_OFFSET), g >= SLANT_OFFSET, under,
                             4'($urandom_range(0, 15)));
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_font_preload();
        test_glyph_mapping();
        test_colors();
        test_dropped_writes();
        test_random_traffic();
        wait_idle(40);
        if (fail_count == 0) begin
            $display("caption_glyph_rasterizer regression: pass");
        end else begin
            $display("caption_glyph_rasterizer regression: fail");
        end
        $finish;
    end

    // Sink: random stalls, with quiet stretches where it never stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            sink_burst <= !sink_burst;
        end
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!sink_burst && $urandom_range(0, 3) == 0) begin
            sink_hold <= idle_length() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check each pixel row against the oldest owed row
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_row.row_index = m_axis_tdata[0 +: ccgr_pkg::ROW_W];
            got_row.pixels = m_axis_tdata[ccgr_pkg::ROW_W +: ccgr_pkg::PIX_W];
            got_row.last_row = m_axis_tlast;
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row: row %0d pixels %h last %0b", $time,
                         got_row.row_index, got_row.pixels, got_row.last_row);
                fail_count++;
            end else begin
                want_row = pending_rows.pop_front();
                if (got_row.row_index !== want_row.row_index
                        || got_row.pixels !== want_row.pixels
                        || got_row.last_row !== want_row.last_row) begin
                    $display("%0t: row mismatch: expected row %0d pixels %h last %0b",
                             $time, want_row.row_index, want_row.pixels, want_row.last_row);
                    $display("%0t:                 actual row %0d pixels %h last %0b",
                             $time, got_row.row_index, got_row.pixels, got_row.last_row);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("caption_glyph_rasterizer regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
